@@ hw/rtl/clce_pkg.sv @@
// ----------------------------------------------------------------------------
// clce_pkg
// Shared types and codes for the circular list cursor engine: operation and
// status codes, request and response items and the sequencer states.
// ----------------------------------------------------------------------------
package clce_pkg;

	typedef enum logic [1:0] {
		OP_INSERT   = 2'd0,
		OP_REMOVE   = 2'd1,
		OP_FORWARD  = 2'd2,
		OP_BACKWARD = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		op_t         operation;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] front_value;
		logic [31:0] back_value;
		logic        list_empty;
		logic [6:0]  entry_count;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS1,
		S_INS2,
		S_RM1,
		S_FW1,
		S_BW1,
		S_VALF,
		S_VALB,
		S_DONE
	} state_t;

endpackage

@@ hw/rtl/circular_list_cursor_engine_unit.sv @@
// ----------------------------------------------------------------------------
// circular_list_cursor_engine_unit
// Circular doubly linked list in a fixed node pool with a free-index stack
// and a cursor; insert/remove after the cursor, cursor forward/backward.
// ----------------------------------------------------------------------------
// sequence: remove runs RM1 then VALF, forward FW1 then VALF, backward BW1 then
//   VALB, insert into a non-empty list INS1 then INS2, insert into an empty list
//   INS1 only; refused, empty-list and last-node items go straight to DONE
// throughput is set by dependent reads through the link and value memories
// reset: async active low; list empty, cursor 0, free stack full; memories
//   are not cleared, the free stack reads its reset contents below a low mark
// ----------------------------------------------------------------------------
module circular_list_cursor_engine_unit #(
	parameter int CAPACITY   = 64,
	parameter int ELEM_WIDTH = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  clce_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output clce_pkg::rsp_t  rsp
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

	// node pool and free stack, one read and one write port each
	logic [ELEM_WIDTH-1:0] value_mem [CAPACITY];
	logic [IDX_W-1:0]      next_mem  [CAPACITY];
	logic [IDX_W-1:0]      prev_mem  [CAPACITY];
	logic [IDX_W-1:0]      free_mem  [CAPACITY];

	clce_pkg::state_t state_q, state_d;

	// cached view of the cursor neighbourhood
	logic [IDX_W-1:0]      cur_q;
	logic [IDX_W-1:0]      nxt_q;
	logic [ELEM_WIDTH-1:0] front_q;
	logic [ELEM_WIDTH-1:0] back_q;
	logic [CNT_W-1:0]      count_q;
	// lowest free count ever reached; stack slots below it were never written
	logic [CNT_W-1:0]      low_mark_q;

	// per-item registers
	clce_pkg::status_t     status_q;
	logic [ELEM_WIDTH-1:0] ins_val_q;
	logic [CNT_W-1:0]      pos_q;
	logic [IDX_W-1:0]      node_q;

	// registered memory read data
	logic [ELEM_WIDTH-1:0] val_rd_q;
	logic [IDX_W-1:0]      next_rd_q;
	logic [IDX_W-1:0]      prev_rd_q;
	logic [IDX_W-1:0]      free_rd_q;

	// memory port controls
	logic                  val_re, val_we;
	logic [IDX_W-1:0]      val_ra, val_wa;
	logic                  next_re, next_we;
	logic [IDX_W-1:0]      next_ra, next_wa, next_wd;
	logic                  prev_re, prev_we;
	logic [IDX_W-1:0]      prev_ra, prev_wa, prev_wd;
	logic                  free_re, free_we;
	logic [IDX_W-1:0]      free_ra, free_wa;

	logic                  accept;
	logic                  list_is_empty;
	logic                  list_is_full;
	logic [CNT_W-1:0]      pop_pos;
	logic [IDX_W-1:0]      node_c;
	logic                  rsp_load;

	assign req_stall     = (state_q != clce_pkg::S_IDLE);
	assign accept        = req_valid && !req_stall;
	assign list_is_empty = (count_q == '0);
	assign list_is_full  = (count_q == CAP_C);
	assign pop_pos       = CAP_C - count_q - ONE_C;
	assign rsp_load      = (state_q == clce_pkg::S_DONE) && (!rsp_valid || !rsp_stall);

	// popped node: stack slot never written yet holds its reset index
	assign node_c = (pos_q < low_mark_q) ? IDX_W'(CAP_C - ONE_C - pos_q) : free_rd_q;

	// ------------------------------------------------------------------------
	// sequencer: next state and memory port controls
	// ------------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		val_re  = 1'b0;
		val_ra  = next_rd_q;
		val_we  = 1'b0;
		val_wa  = node_c;
		next_re = 1'b0;
		next_ra = nxt_q;
		next_we = 1'b0;
		next_wa = node_c;
		next_wd = list_is_empty ? node_c : nxt_q;
		prev_re = 1'b0;
		prev_ra = cur_q;
		prev_we = 1'b0;
		prev_wa = node_c;
		prev_wd = list_is_empty ? node_c : cur_q;
		free_re = 1'b0;
		free_ra = IDX_W'(pop_pos);
		free_we = 1'b0;
		free_wa = IDX_W'(CAP_C - count_q);
		case (state_q)
			clce_pkg::S_IDLE: begin
				if (accept) begin
					case (req.operation)
						clce_pkg::OP_INSERT: begin
							if (list_is_full) begin
								state_d = clce_pkg::S_DONE;
							end else begin
								free_re = 1'b1;
								state_d = clce_pkg::S_INS1;
							end
						end
						clce_pkg::OP_REMOVE: begin
							if (list_is_empty) begin
								state_d = clce_pkg::S_DONE;
							end else if (count_q == ONE_C) begin
								// last node goes straight back on the stack
								free_we = 1'b1;
								state_d = clce_pkg::S_DONE;
							end else begin
								next_re = 1'b1;
								state_d = clce_pkg::S_RM1;
							end
						end
						clce_pkg::OP_FORWARD: begin
							if (list_is_empty) begin
								state_d = clce_pkg::S_DONE;
							end else begin
								next_re = 1'b1;
								state_d = clce_pkg::S_FW1;
							end
						end
						default: begin
							if (list_is_empty) begin
								state_d = clce_pkg::S_DONE;
							end else begin
								prev_re = 1'b1;
								state_d = clce_pkg::S_BW1;
							end
						end
					endcase
				end
			end
			clce_pkg::S_INS1: begin
				// new node: value and both links
				val_we  = 1'b1;
				next_we = 1'b1;
				prev_we = 1'b1;
				state_d = list_is_empty ? clce_pkg::S_DONE : clce_pkg::S_INS2;
			end
			clce_pkg::S_INS2: begin
				// splice between cursor and its old successor
				next_we = 1'b1;
				next_wa = cur_q;
				next_wd = node_q;
				prev_we = 1'b1;
				prev_wa = nxt_q;
				prev_wd = node_q;
				state_d = clce_pkg::S_DONE;
			end
			clce_pkg::S_RM1: begin
				// unlink the node after the cursor, push it, fetch new front
				next_we = 1'b1;
				next_wa = cur_q;
				next_wd = next_rd_q;
				prev_we = 1'b1;
				prev_wa = next_rd_q;
				prev_wd = cur_q;
				free_we = 1'b1;
				val_re  = 1'b1;
				state_d = clce_pkg::S_VALF;
			end
			clce_pkg::S_FW1: begin
				val_re  = 1'b1;
				state_d = clce_pkg::S_VALF;
			end
			clce_pkg::S_BW1: begin
				val_re  = 1'b1;
				val_ra  = prev_rd_q;
				state_d = clce_pkg::S_VALB;
			end
			clce_pkg::S_VALF: state_d = clce_pkg::S_DONE;
			clce_pkg::S_VALB: state_d = clce_pkg::S_DONE;
			clce_pkg::S_DONE: begin
				if (rsp_load) begin
					state_d = clce_pkg::S_IDLE;
				end
			end
			default: state_d = clce_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clce_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------------
	// memories, read data registered
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (val_we) begin
			value_mem[val_wa] <= ins_val_q;
		end
		if (val_re) begin
			val_rd_q <= value_mem[val_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		if (next_re) begin
			next_rd_q <= next_mem[next_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		if (prev_re) begin
			prev_rd_q <= prev_mem[prev_ra];
		end
	end

	// free stack push always carries the node that was after the cursor
	always_ff @(posedge clk) begin
		if (free_we) begin
			free_mem[free_wa] <= nxt_q;
		end
		if (free_re) begin
			free_rd_q <= free_mem[free_ra];
		end
	end

	// ------------------------------------------------------------------------
	// list control state
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q      <= '0;
			nxt_q      <= '0;
			count_q    <= '0;
			low_mark_q <= CAP_C;
			status_q   <= clce_pkg::ST_OK;
		end else begin
			case (state_q)
				clce_pkg::S_IDLE: begin
					if (accept) begin
						case (req.operation)
							clce_pkg::OP_INSERT: begin
								status_q <= list_is_full ? clce_pkg::ST_FULL
									: clce_pkg::ST_OK;
							end
							clce_pkg::OP_REMOVE: begin
								if (list_is_empty) begin
									status_q <= clce_pkg::ST_EMPTY;
								end else begin
									status_q <= clce_pkg::ST_OK;
									if (count_q == ONE_C) begin
										count_q <= '0;
										cur_q   <= '0;
									end
								end
							end
							clce_pkg::OP_FORWARD: begin
								if (list_is_empty) begin
									status_q <= clce_pkg::ST_EMPTY;
								end else begin
									status_q <= clce_pkg::ST_OK;
									cur_q    <= nxt_q;
								end
							end
							default: begin
								if (list_is_empty) begin
									status_q <= clce_pkg::ST_EMPTY;
								end else begin
									status_q <= clce_pkg::ST_OK;
									nxt_q    <= cur_q;
								end
							end
						endcase
					end
				end
				clce_pkg::S_INS1: begin
					count_q <= count_q + ONE_C;
					if (pos_q < low_mark_q) begin
						low_mark_q <= pos_q;
					end
					if (list_is_empty) begin
						cur_q <= node_c;
						nxt_q <= node_c;
					end
				end
				clce_pkg::S_INS2: nxt_q <= node_q;
				clce_pkg::S_RM1: begin
					nxt_q   <= next_rd_q;
					count_q <= count_q - ONE_C;
				end
				clce_pkg::S_FW1: nxt_q <= next_rd_q;
				clce_pkg::S_BW1: cur_q <= prev_rd_q;
				default: ;
			endcase
		end
	end

	// payload side: values around the cursor and per-item data
	always_ff @(posedge clk) begin
		case (state_q)
			clce_pkg::S_IDLE: begin
				if (accept) begin
					ins_val_q <= ELEM_WIDTH'(req.value);
					pos_q     <= pop_pos;
					if (!list_is_empty && req.operation == clce_pkg::OP_FORWARD) begin
						back_q <= front_q;
					end
					if (!list_is_empty && req.operation == clce_pkg::OP_BACKWARD) begin
						front_q <= back_q;
					end
				end
			end
			clce_pkg::S_INS1: begin
				node_q  <= node_c;
				front_q <= ins_val_q;
				if (list_is_empty) begin
					back_q <= ins_val_q;
				end
			end
			clce_pkg::S_VALF: front_q <= val_rd_q;
			clce_pkg::S_VALB: back_q  <= val_rd_q;
			default: ;
		endcase
	end

	// ------------------------------------------------------------------------
	// result register, parts the engine from the consumer
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp.status      <= status_q;
			rsp.front_value <= list_is_empty ? 32'd0 : 32'(front_q);
			rsp.back_value  <= list_is_empty ? 32'd0 : 32'(back_q);
			rsp.list_empty  <= list_is_empty;
			rsp.entry_count <= 7'(count_q);
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("node count above pool size");

	a_low_mark: assert property (@(posedge clk) disable iff (!arst_n)
		low_mark_q <= CAP_C - count_q)
		else $error("free stack low mark above free count");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != clce_pkg::S_IDLE)
		else $error("engine idle right after taking an item");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == clce_pkg::S_DONE && rsp_valid && rsp_stall) |=>
		state_q == clce_pkg::S_DONE)
		else $error("result dropped while output register full");
`endif

endmodule

@@ bench/circular_list_cursor_engine_unit_test.sv @@
// ----------------------------------------------------------------------------
// circular_list_cursor_engine_unit_test
// Self-checking bench for the circular list cursor engine. A short directed
// table covers the empty list, a single node and the value extremes. Random
// segments then grow the list to a full pool, shrink it past empty and move
// the cursor around. Each accepted request is run through a bench model of
// the list, and every response is compared field by field in order.
// ----------------------------------------------------------------------------
module circular_list_cursor_engine_unit_test;

	localparam int CAP            = 64;
	localparam int RANDOM_ITEMS   = 1200;
	localparam int CALM_TAIL      = 150;  // last random items run with no idling
	localparam int LONG_HOLD      = 400;  // long response hold-off, in cycles
	localparam int WATCHDOG_LIMIT = 4000; // cycles with no item moving on either side
	localparam int REPORT_LIMIT   = 10;

	typedef struct {
		clce_pkg::req_t item;
		bit             pinned;   // response typed into the table
		clce_pkg::rsp_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	clce_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	clce_pkg::rsp_t rsp;

	// pinned response travels with the request it belongs to
	bit             pin_now = 1'b0;
	clce_pkg::rsp_t pin_want = '0;

	// bench copy of the list: node pool, links, free-index stack, cursor
	logic [31:0] node_val [CAP];
	logic [5:0]  link_fwd [CAP];
	logic [5:0]  link_bwd [CAP];
	logic [5:0]  spare_stack [CAP];
	int          spare_top;
	logic [5:0]  cursor;
	int          population;

	clce_pkg::rsp_t awaited[$];
	row_t directed[$];

	// idling odds shared with the receiver process; 0 means none
	int gap_odds = 0;
	int rx_odds = 0;
	bit long_hold_req = 1'b0;

	int mismatches = 0;
	int stuck_cycles = 0;
	int items_in = 0;
	int results_out = 0;
	int full_refusals = 0;
	int empty_hits = 0;
	int last_removals = 0;
	int peak_population = 0;

	circular_list_cursor_engine_unit #(
		.CAPACITY  (CAP),
		.ELEM_WIDTH(32)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// bench model: apply one request to the list and give the response it causes
	task automatic advance_list(input clce_pkg::req_t r, output clce_pkg::rsp_t o);
		logic [5:0]        node;
		logic [5:0]        nxt;
		logic [5:0]        far;
		clce_pkg::status_t st;
		st = clce_pkg::ST_OK;
		case (r.operation)
			clce_pkg::OP_INSERT: begin
				if (population == CAP) begin
					st = clce_pkg::ST_FULL;
				end else begin
					spare_top--;
					node = spare_stack[spare_top];
					node_val[node] = r.value;
					if (population == 0) begin
						// lone node links to itself and takes the cursor
						link_fwd[node] = node;
						link_bwd[node] = node;
						cursor = node;
					end else begin
						nxt = link_fwd[cursor];
						link_fwd[node] = nxt;
						link_bwd[node] = cursor;
						link_bwd[nxt] = node;
						link_fwd[cursor] = node;
					end
					population++;
				end
			end
			clce_pkg::OP_REMOVE: begin
				if (population == 0) begin
					st = clce_pkg::ST_EMPTY;
				end else begin
					node = link_fwd[cursor];
					if (population == 1) begin
						cursor = '0;
					end else begin
						far = link_fwd[node];
						link_fwd[cursor] = far;
						link_bwd[far] = cursor;
					end
					spare_stack[spare_top] = node;
					spare_top++;
					population--;
				end
			end
			clce_pkg::OP_FORWARD: begin
				if (population == 0)
					st = clce_pkg::ST_EMPTY;
				else
					cursor = link_fwd[cursor];
			end
			default: begin
				if (population == 0)
					st = clce_pkg::ST_EMPTY;
				else
					cursor = link_bwd[cursor];
			end
		endcase
		o.status      = st;
		o.list_empty  = (population == 0);
		o.entry_count = population[6:0];
		if (population != 0) begin
			o.front_value = node_val[link_fwd[cursor]];
			o.back_value  = node_val[cursor];
		end else begin
			o.front_value = '0;
			o.back_value  = '0;
		end
	endtask

	// observe both channels at the rising edge, before the block updates
	always @(posedge clk) begin : observe
		clce_pkg::rsp_t modelled;
		clce_pkg::rsp_t want;
		bit             moved;
		moved = 1'b0;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				advance_list(req, modelled);
				awaited.push_back(pin_now ? pin_want : modelled);
				items_in++;
				moved = 1'b1;
				if (modelled.status == clce_pkg::ST_FULL)
					full_refusals++;
				if (modelled.status == clce_pkg::ST_EMPTY)
					empty_hits++;
				if (req.operation == clce_pkg::OP_REMOVE
						&& modelled.status == clce_pkg::ST_OK
						&& modelled.list_empty)
					last_removals++;
				if (population > peak_population)
					peak_population = population;
			end
			if (rsp_valid && !rsp_stall) begin
				moved = 1'b1;
				results_out++;
				if (awaited.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display({"unexpected response item: ",
							"status %0d front %h back %h empty %b count %0d"},
							rsp.status, rsp.front_value, rsp.back_value,
							rsp.list_empty, rsp.entry_count);
				end else begin
					want = awaited.pop_front();
					if (rsp.status !== want.status
							|| rsp.front_value !== want.front_value
							|| rsp.back_value !== want.back_value
							|| rsp.list_empty !== want.list_empty
							|| rsp.entry_count !== want.entry_count) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display({"response %0d mismatch: ",
								"expected %0d/%h/%h/%b/%0d got %0d/%h/%h/%b/%0d"},
								results_out, want.status, want.front_value,
								want.back_value, want.list_empty, want.entry_count,
								rsp.status, rsp.front_value, rsp.back_value,
								rsp.list_empty, rsp.entry_count);
					end
				end
			end
			stuck_cycles = moved ? 0 : stuck_cycles + 1;
		end
	end

	// watchdog: nothing moving for too long means the block has hung
	initial begin
		wait (stuck_cycles >= WATCHDOG_LIMIT);
		$display("watchdog: no item moved for %0d cycles, %0d responses still awaited",
			WATCHDOG_LIMIT, awaited.size());
		$display("FAILURE");
		$finish;
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				rsp_stall <= 1'b0;
			end else if (rx_odds != 0 && $urandom_range(1, rx_odds) == 1) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(negedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	// offer one item from a falling edge and hold it until accepted
	task automatic send_item(input clce_pkg::op_t op, input logic [31:0] v,
			input bit pin, input clce_pkg::rsp_t want);
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		req_valid <= 1'b1;
		req.operation <= op;
		req.value <= v;
		pin_now <= pin;
		pin_want <= want;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// sender goes quiet until every awaited response has come back
	task automatic pause_until_drained();
		req_valid <= 1'b0;
		while (awaited.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic add_row(input clce_pkg::op_t op, input logic [31:0] v, input bit pin,
			input clce_pkg::rsp_t want);
		row_t row;
		row.item.operation = op;
		row.item.value = v;
		row.pinned = pin;
		row.want = want;
		directed.push_back(row);
	endtask

	initial begin : stimulus
		int            sent;
		int            seg;
		int            seg_len;
		int            mode;
		int            roll;
		int            k;
		clce_pkg::op_t op;
		logic [31:0]   v;

		// bench list after reset: empty, cursor 0, free stack holds every node
		for (int i = 0; i < CAP; i++) begin
			node_val[i] = '0;
			link_fwd[i] = '0;
			link_bwd[i] = '0;
			spare_stack[i] = 6'(CAP - 1 - i);
		end
		spare_top = CAP;
		cursor = '0;
		population = 0;

		// directed table: empty list, lone node, value extremes, walk and unwind
		add_row(clce_pkg::OP_FORWARD, 32'h1234_5678, 1'b1,
			'{clce_pkg::ST_EMPTY, 32'd0, 32'd0, 1'b1, 7'd0});
		add_row(clce_pkg::OP_BACKWARD, 32'hFFFF_FFFF, 1'b1,
			'{clce_pkg::ST_EMPTY, 32'd0, 32'd0, 1'b1, 7'd0});
		add_row(clce_pkg::OP_REMOVE, 32'd0, 1'b1,
			'{clce_pkg::ST_EMPTY, 32'd0, 32'd0, 1'b1, 7'd0});
		add_row(clce_pkg::OP_INSERT, 32'd0, 1'b1,
			'{clce_pkg::ST_OK, 32'd0, 32'd0, 1'b0, 7'd1});
		add_row(clce_pkg::OP_REMOVE, 32'd7, 1'b1,
			'{clce_pkg::ST_OK, 32'd0, 32'd0, 1'b1, 7'd0});
		add_row(clce_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1,
			'{clce_pkg::ST_OK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 7'd1});
		add_row(clce_pkg::OP_FORWARD, 32'd0, 1'b0, '0);
		add_row(clce_pkg::OP_BACKWARD, 32'd0, 1'b0, '0);
		add_row(clce_pkg::OP_INSERT, 32'd0, 1'b0, '0);
		add_row(clce_pkg::OP_INSERT, 32'h8000_0000, 1'b0, '0);
		add_row(clce_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b0, '0);
		add_row(clce_pkg::OP_INSERT, 32'h5555_5555, 1'b0, '0);
		add_row(clce_pkg::OP_INSERT, 32'hAAAA_AAAA, 1'b0, '0);
		add_row(clce_pkg::OP_FORWARD, 32'hFFFF_FFFF, 1'b0, '0);
		add_row(clce_pkg::OP_FORWARD, 32'd1, 1'b0, '0);
		add_row(clce_pkg::OP_BACKWARD, 32'd2, 1'b0, '0);
		for (int i = 0; i < 5; i++)
			add_row(clce_pkg::OP_REMOVE, 32'd0, 1'b0, '0);
		add_row(clce_pkg::OP_REMOVE, 32'hFFFF_FFFF, 1'b1,
			'{clce_pkg::ST_OK, 32'd0, 32'd0, 1'b1, 7'd0});
		add_row(clce_pkg::OP_BACKWARD, 32'd0, 1'b1,
			'{clce_pkg::ST_EMPTY, 32'd0, 32'd0, 1'b1, 7'd0});

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part with light idling on both sides
		gap_odds = 4;
		rx_odds = 4;
		foreach (directed[i])
			send_item(directed[i].item.operation, directed[i].item.value,
				directed[i].pinned, directed[i].want);
		pause_until_drained();

		// random part in segments: grow, shrink, wander and mixed traffic
		sent = 0;
		seg = 0;
		while (sent < RANDOM_ITEMS) begin
			mode = (seg == 0) ? 0 : (seg == 1) ? 1 : $urandom_range(0, 3);
			seg_len = (seg < 2) ? 110 : $urandom_range(20, 120);
			if (sent >= RANDOM_ITEMS - CALM_TAIL) begin
				gap_odds = 0;
				rx_odds = 0;
			end else begin
				k = $urandom_range(0, 2);
				gap_odds = (k == 0) ? 0 : (k == 1) ? 3 : 8;
				k = $urandom_range(0, 2);
				rx_odds = (k == 0) ? 0 : (k == 1) ? 3 : 8;
			end
			// third segment: long receiver hold-off while requests keep coming
			if (seg == 2) begin
				gap_odds = 0;
				long_hold_req = 1'b1;
			end
			for (int n = 0; n < seg_len && sent < RANDOM_ITEMS; n++) begin
				// the tail runs with no idling on either side
				if (sent == RANDOM_ITEMS - CALM_TAIL) begin
					gap_odds = 0;
					rx_odds = 0;
				end
				roll = $urandom_range(0, 99);
				case (mode)
					0: op = (roll < 90) ? clce_pkg::OP_INSERT
						: clce_pkg::op_t'($urandom_range(1, 3));
					1: op = (roll < 90) ? clce_pkg::OP_REMOVE
						: clce_pkg::op_t'($urandom_range(0, 3));
					2: op = (roll < 70) ? clce_pkg::op_t'($urandom_range(2, 3))
						: clce_pkg::op_t'($urandom_range(0, 1));
					default: op = clce_pkg::op_t'($urandom_range(0, 3));
				endcase
				// value extremes now and then, otherwise a full-width random word
				k = $urandom_range(0, 9);
				if (k == 0)
					v = 32'd0;
				else if (k == 1)
					v = 32'hFFFF_FFFF;
				else if (k == 2)
					v = 32'd1 << $urandom_range(0, 31);
				else
					v = $urandom;
				send_item(op, v, 1'b0, '0);
				sent++;
			end
			// drain fully after the shrink segment and now and then outside the tail
			if (seg == 1 || (sent < RANDOM_ITEMS - CALM_TAIL
					&& $urandom_range(0, 3) == 0))
				pause_until_drained();
			seg++;
		end

		// end of stimulus: let every awaited response arrive, then settle
		req_valid <= 1'b0;
		while (awaited.size() != 0) @(negedge clk);
		repeat (12) @(negedge clk);

		$display("run covered %0d requests and %0d responses over %0d random segments",
			items_in, results_out, seg);
		$display({"peak occupancy %0d, %0d full-pool refusals, ",
			"%0d empty-list items, %0d last-node removals"},
			peak_population, full_refusals, empty_hits, last_removals);
		if (mismatches == 0 && awaited.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
